[rtl/assert_macros.svh]
// Assertion macros shared by the RTL of the palette to packed RGB unit.
// Each macro expects the including module to have ports named clock and reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, inactive while reset is high.
`define P2R_ASSERT_NOW(lbl, lhs, rhs, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (lhs) |-> (rhs)) \
      else $error(msg);

// Next-cycle implication, inactive while reset is high.
`define P2R_ASSERT_NEXT(lbl, lhs, rhs, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (lhs) |=> (rhs)) \
      else $error(msg);

`endif

[rtl/p2rgb_pkg.sv]
// Package for the palette to packed RGB unit: channel format types, codes,
// reset masks and the mask decode and channel placement functions. No dependencies.
`default_nettype none

package p2rgb_pkg;

   localparam int unsigned CHAN_BITS  = 8;
   localparam int unsigned MASK_BITS  = 16;
   localparam int unsigned COLOR_BITS = 24;

   // Input beat kinds, carried on req_tuser.
   localparam logic ACTION_WRITE   = 1'b0;
   localparam logic ACTION_CONVERT = 1'b1;

   // Configuration register indexes.
   localparam logic [1:0] CSR_RED_MASK   = 2'd0;
   localparam logic [1:0] CSR_GREEN_MASK = 2'd1;
   localparam logic [1:0] CSR_BLUE_MASK  = 2'd2;

   // Reset masks give the 5-6-5 layout.
   localparam logic [MASK_BITS-1:0] RED_MASK_RESET   = 16'hF800;
   localparam logic [MASK_BITS-1:0] GREEN_MASK_RESET = 16'h07E0;
   localparam logic [MASK_BITS-1:0] BLUE_MASK_RESET  = 16'h001F;

   // Decoded form of one channel mask: bit position and clamped width (0 to 8).
   typedef struct packed {
      logic [3:0] pos;
      logic [3:0] width;
   } chan_fmt_type;

   typedef struct packed {
      chan_fmt_type red;
      chan_fmt_type green;
      chan_fmt_type blue;
   } pixel_fmt_type;

   // Position is the count of trailing zeros; width is the run of ones above it,
   // looked at over eight bits only, which clamps it to eight.
   function automatic chan_fmt_type decode_mask(input logic [MASK_BITS-1:0] mask);
      chan_fmt_type          fmt;
      logic [MASK_BITS-1:0]  shifted;
      fmt.pos   = 4'd0;
      fmt.width = 4'd8;
      for (int i = MASK_BITS - 1; i >= 0; i--) begin
         if (mask[i]) begin
            fmt.pos = 4'(i);
         end
      end
      shifted = mask >> fmt.pos;
      for (int i = CHAN_BITS - 1; i >= 0; i--) begin
         if (!shifted[i]) begin
            fmt.width = 4'(i);
         end
      end
      return fmt;
   endfunction

   // Keeps the top bits of an 8-bit channel and moves them to their place.
   function automatic logic [MASK_BITS-1:0] place_channel(input logic [CHAN_BITS-1:0] chan,
                                                          input chan_fmt_type         fmt);
      logic [CHAN_BITS-1:0] kept;
      kept = chan >> (4'd8 - fmt.width);
      return {8'd0, kept} << fmt.pos;
   endfunction

endpackage

`default_nettype wire

[rtl/p2rgb_ram.sv]
// Generic single-port synchronous RAM with a registered read port.
// Used for the palette store of the palette to packed RGB unit; no dependencies.
`default_nettype none

module p2rgb_ram #(
   parameter int unsigned WIDTH = 24,
   parameter int unsigned DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // A write or a read of the addressed word; the two enables may also be set together.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[rtl/p2rgb_pack.sv]
// Packs a 24-bit palette colour into a 16-bit pixel under the decoded channel formats.
// Depends on p2rgb_pkg.
`default_nettype none

module p2rgb_pack
   import p2rgb_pkg::*;
(
   input  wire logic [COLOR_BITS-1:0] colour,
   input  wire pixel_fmt_type         fmt,
   output logic      [MASK_BITS-1:0]  pixel
);

   logic [MASK_BITS-1:0] red_part;
   logic [MASK_BITS-1:0] green_part;
   logic [MASK_BITS-1:0] blue_part;

   // Place each channel, then add them; carries out of bit 15 are dropped.
   always_comb begin
      red_part   = place_channel(colour[23:16], fmt.red);
      green_part = place_channel(colour[15:8],  fmt.green);
      blue_part  = place_channel(colour[7:0],   fmt.blue);
      pixel      = red_part + green_part + blue_part;
   end

endmodule

`default_nettype wire

[rtl/palette_to_packed_rgb_unit.sv]
// Top level of the palette to packed RGB unit: palette RAM, channel format registers
// and the two-stage result path. Depends on p2rgb_pkg, p2rgb_ram, p2rgb_pack.
//
//   Port group | Direction | Beat contents
//   req_       | in        | tdata: entry_index, entry_rgb; tuser: action
//   rsp_       | out       | tdata: packed_pixel
//   csr_       | in        | write enable, register index, 16-bit mask
//
// One beat is accepted per cycle while req_tready is high, writes and converts mixed freely.
// A convert reads the palette RAM at the accepting edge; its pixel enters the output
// register once that register is empty or being taken, and the result beat is offered from it.
// Reset is synchronous and restores the 5-6-5 masks; the palette is undefined until written.
// A stall on rsp_ holds the read stage and then req_tready falls.
`default_nettype none

module palette_to_packed_rgb_unit
   import p2rgb_pkg::*;
#(
   parameter int unsigned PALETTE_DEPTH = 256
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // Input channel.
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // [7:0] entry_index, [31:8] entry_rgb
   input  wire logic        req_tuser,   // [0] action
   // Result channel.
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [15:0] rsp_tdata,   // [15:0] packed_pixel
   // Configuration port.
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_wdata
);

   `include "assert_macros.svh"

   localparam int unsigned ADDR_BITS = $clog2(PALETTE_DEPTH);

   logic [CHAN_BITS-1:0]  req_index;
   logic [COLOR_BITS-1:0] req_rgb;
   logic                  req_accept;
   logic                  in_range;
   logic                  s1_go;

   pixel_fmt_type         fmt_ff, fmt_in;
   logic                  s1_valid_ff, s1_valid_in;
   logic                  s1_oob_ff, s1_oob_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [MASK_BITS-1:0]  rsp_pixel_ff, rsp_pixel_in;

   logic [COLOR_BITS-1:0] ram_rdata;
   logic [COLOR_BITS-1:0] colour;
   logic [MASK_BITS-1:0]  packed_pixel;

   // Beat fields and handshake.
   assign req_index  = req_tdata[7:0];
   assign req_rgb    = req_tdata[31:8];
   assign s1_go      = !rsp_valid_ff || rsp_tready;
   assign req_tready = !s1_valid_ff || s1_go;
   assign req_accept = req_tvalid && req_tready;
   assign in_range   = {1'b0, req_index} < 9'(PALETTE_DEPTH);

   // Mask registers are held in decoded form.
   always_comb begin
      fmt_in = fmt_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_RED_MASK:   fmt_in.red   = decode_mask(csr_wdata);
            CSR_GREEN_MASK: fmt_in.green = decode_mask(csr_wdata);
            CSR_BLUE_MASK:  fmt_in.blue  = decode_mask(csr_wdata);
            default:        fmt_in       = fmt_ff;
         endcase
      end
   end

   // Palette store: an in-range write beat writes, a convert beat reads the same port.
   p2rgb_ram #(
      .WIDTH (COLOR_BITS),
      .DEPTH (PALETTE_DEPTH)
   ) u_palette (
      .clock   (clock),
      .wr_en   (req_accept && (req_tuser == ACTION_WRITE) && in_range),
      .rd_en   (req_accept && (req_tuser == ACTION_CONVERT)),
      .addr    (req_index[ADDR_BITS-1:0]),
      .wr_data (req_rgb),
      .rd_data (ram_rdata)
   );

   // An index beyond the palette reads as black.
   assign colour = s1_oob_ff ? '0 : ram_rdata;

   p2rgb_pack u_pack (
      .colour (colour),
      .fmt    (fmt_ff),
      .pixel  (packed_pixel)
   );

   // Read stage and output register control.
   always_comb begin
      s1_valid_in  = s1_valid_ff;
      s1_oob_in    = s1_oob_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_pixel_in = rsp_pixel_ff;
      if (s1_go) begin
         rsp_valid_in = s1_valid_ff;
         s1_valid_in  = 1'b0;
         if (s1_valid_ff) begin
            rsp_pixel_in = packed_pixel;
         end
      end
      if (req_accept) begin
         s1_valid_in = (req_tuser == ACTION_CONVERT);
         s1_oob_in   = !in_range;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_ff       <= '{red:   decode_mask(RED_MASK_RESET),
                           green: decode_mask(GREEN_MASK_RESET),
                           blue:  decode_mask(BLUE_MASK_RESET)};
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fmt_ff       <= fmt_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      s1_oob_ff    <= s1_oob_in;
      rsp_pixel_ff <= rsp_pixel_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_pixel_ff;

   // Checks on the read stage.
   `P2R_ASSERT_NEXT(a_write_no_read, req_accept && (req_tuser == ACTION_WRITE),
      !s1_valid_ff, "palette write beat occupied the read stage")
   `P2R_ASSERT_NEXT(a_convert_reads, req_accept && (req_tuser == ACTION_CONVERT),
      s1_valid_ff, "convert beat did not reach the read stage")
   `P2R_ASSERT_NEXT(a_stall_holds, s1_valid_ff && !s1_go,
      s1_valid_ff, "stalled read stage lost its item")
   `P2R_ASSERT_NEXT(a_oob_flag, req_accept && (req_tuser == ACTION_CONVERT) && !in_range,
      s1_oob_ff, "out of range convert not flagged")

endmodule

`default_nettype wire

[bench/palette_to_packed_rgb_checker.sv]
`timescale 1ns / 100ps
// Checker for the palette to packed RGB unit: it follows the palette and mask writes,
// predicts each packed pixel and compares the result beats in order. Depends on p2rgb_pkg.

module palette_to_packed_rgb_checker
   import p2rgb_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [31:0] req_tdata,   // [7:0] entry_index, [31:8] entry_rgb
   input  wire logic        req_tuser,   // [0] action
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [15:0] rsp_tdata,   // [15:0] packed_pixel
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_wdata,
   output int               failures,
   output int               outstanding
);

   // Shadow copy of the palette and of the three channel masks.
   logic [COLOR_BITS-1:0] colour_table [256];
   logic [MASK_BITS-1:0]  red_sel   = RED_MASK_RESET;
   logic [MASK_BITS-1:0]  green_sel = GREEN_MASK_RESET;
   logic [MASK_BITS-1:0]  blue_sel  = BLUE_MASK_RESET;
   logic [15:0]           pending_pixels [$];
   int                    fail_total = 0;

   initial begin
      failures    = 0;
      outstanding = 0;
   end

   // Position is the count of trailing zeros, width the run of ones just above them.
   // A zero mask yields width zero, so the channel contributes nothing.
   function automatic logic [15:0] place_bits(input logic [7:0]  chan,
                                              input logic [15:0] mask);
      logic [15:0] m;
      int          pos;
      int          width;
      logic [31:0] wide;
      m     = mask;
      pos   = 0;
      width = 0;
      if (m != 16'd0) begin
         while (!m[0]) begin
            m = m >> 1;
            pos++;
         end
      end
      while (m[0]) begin
         m = m >> 1;
         width++;
      end
      if (width > CHAN_BITS) begin
         width = CHAN_BITS;
      end
      wide = 32'(chan) >> (CHAN_BITS - width);
      wide = wide << pos;
      return wide[15:0];
   endfunction

   // The three placed channels are summed and carries above bit 15 are dropped.
   function automatic logic [15:0] packed_from_colour(input logic [23:0] colour,
                                                      input logic [15:0] rmask,
                                                      input logic [15:0] gmask,
                                                      input logic [15:0] bmask);
      logic [15:0] total;
      total = place_bits(colour[23:16], rmask);
      total = total + place_bits(colour[15:8], gmask);
      total = total + place_bits(colour[7:0], bmask);
      return total;
   endfunction

   // Follow every accepted beat and compare each pixel with the oldest prediction.
   always @(posedge clock) begin
      logic [15:0] want;
      if (reset) begin
         red_sel   = RED_MASK_RESET;
         green_sel = GREEN_MASK_RESET;
         blue_sel  = BLUE_MASK_RESET;
         pending_pixels.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_RED_MASK:   red_sel   = csr_wdata;
               CSR_GREEN_MASK: green_sel = csr_wdata;
               CSR_BLUE_MASK:  blue_sel  = csr_wdata;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            if (req_tuser == ACTION_WRITE) begin
               colour_table[req_tdata[7:0]] = req_tdata[31:8];
            end else begin
               pending_pixels.push_back(packed_from_colour(colour_table[req_tdata[7:0]],
                                                           red_sel, green_sel, blue_sel));
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            if (pending_pixels.size() == 0) begin
               fail_total++;
               $display("%0t: pixel beat 0x%04h arrived with nothing expected",
                        $time, rsp_tdata);
            end else begin
               want = pending_pixels.pop_front();
               if (rsp_tdata !== want) begin
                  fail_total++;
                  $display("%0t: packed_pixel expected 0x%04h actual 0x%04h",
                           $time, want, rsp_tdata);
               end
            end
         end
      end
      failures    <= fail_total;
      outstanding <= pending_pixels.size();
   end

endmodule

[bench/palette_to_packed_rgb_unit_tb.sv]
`timescale 1ns / 100ps
// Top of the bench for the palette to packed RGB unit: clock, reset, stimulus and verdict.
// Depends on p2rgb_pkg, palette_to_packed_rgb_unit and palette_to_packed_rgb_checker.

module palette_to_packed_rgb_unit_tb
   import p2rgb_pkg::*;
();

   localparam int CYCLE_LIMIT   = 200000;
   localparam int DRAIN_CYCLES  = 4;
   localparam int RANDOM_PHASES = 7;
   localparam int PHASE_BEATS   = 250;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata  = 32'd0;
   logic        req_tuser  = ACTION_WRITE;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic        csr_we     = 1'b0;
   logic [1:0]  csr_index  = CSR_RED_MASK;
   logic [15:0] csr_wdata  = 16'd0;

   int          failures;
   int          outstanding;
   int          cycle_count = 0;
   bit          send_calm   = 1'b0;
   bit          take_calm   = 1'b0;
   bit          filled [256];
   int          filled_list [$];

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   palette_to_packed_rgb_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   palette_to_packed_rgb_checker u_check (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .failures    (failures),
      .outstanding (outstanding)
   );

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Result side: stall for a random number of cycles before taking each beat,
   // with occasional stretches of no stalls at all.
   initial begin
      int gap;
      forever begin
         if ($urandom_range(0, 49) == 0) begin
            take_calm = !take_calm;
         end
         gap = take_calm ? 0 : $urandom_range(0, 6);
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (rsp_tvalid !== 1'b1);
      end
   end

   // Offers one input beat after a random gap and returns at the edge that accepts it.
   task automatic send_beat(input logic action, input logic [7:0] idx, input logic [23:0] rgb);
      int gap;
      if ($urandom_range(0, 49) == 0) begin
         send_calm = !send_calm;
      end
      gap = send_calm ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= action;
      req_tdata  <= {rgb, idx};
      do @(posedge clock); while (req_tready !== 1'b1);
      if (action == ACTION_WRITE && !filled[idx]) begin
         filled[idx] = 1'b1;
         filled_list.push_back(int'(idx));
      end
   endtask

   // Drops valid, waits for every predicted pixel, then lets the pipeline drain.
   task automatic settle();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Writes all three masks on consecutive edges; only called while the unit is idle.
   task automatic load_masks(input logic [15:0] rmask, input logic [15:0] gmask,
                             input logic [15:0] bmask);
      csr_we    <= 1'b1;
      csr_index <= CSR_RED_MASK;
      csr_wdata <= rmask;
      @(posedge clock);
      csr_index <= CSR_GREEN_MASK;
      csr_wdata <= gmask;
      @(posedge clock);
      csr_index <= CSR_BLUE_MASK;
      csr_wdata <= bmask;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   // Mostly converts of entries already written, so no unwritten entry is ever read.
   task automatic random_beat();
      logic [23:0] rgb;
      rgb = 24'($urandom);
      if ($urandom_range(0, 9) == 0) begin
         rgb = $urandom_range(0, 1) ? 24'hFFFFFF : 24'h000000;
      end
      if (filled_list.size() == 0 || $urandom_range(0, 99) < 35) begin
         send_beat(ACTION_WRITE, 8'($urandom), rgb);
      end else begin
         send_beat(ACTION_CONVERT, 8'(filled_list[$urandom_range(0, filled_list.size() - 1)]),
                   rgb);
      end
   endtask

   initial begin
      logic [15:0] lane_mask [3];
      int          width;
      int          pos;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed beats under the reset 5-6-5 layout: extremes, pure channels, and a
      // convert straight after a write of the same entry.
      send_beat(ACTION_WRITE, 8'd0, 24'h000000);
      send_beat(ACTION_WRITE, 8'd255, 24'hFFFFFF);
      send_beat(ACTION_WRITE, 8'd1, 24'hFF0000);
      send_beat(ACTION_WRITE, 8'd2, 24'h00FF00);
      send_beat(ACTION_WRITE, 8'd3, 24'h0000FF);
      send_beat(ACTION_WRITE, 8'd128, 24'hA5A5A5);
      send_beat(ACTION_CONVERT, 8'd0, 24'hFFFFFF);
      send_beat(ACTION_CONVERT, 8'd255, 24'h000000);
      send_beat(ACTION_CONVERT, 8'd1, 24'h5A5A5A);
      send_beat(ACTION_CONVERT, 8'd2, 24'h000000);
      send_beat(ACTION_CONVERT, 8'd3, 24'hFFFFFF);
      send_beat(ACTION_CONVERT, 8'd128, 24'h000000);
      send_beat(ACTION_WRITE, 8'd4, 24'h123456);
      send_beat(ACTION_CONVERT, 8'd4, 24'h000000);
      send_beat(ACTION_WRITE, 8'd4, 24'hEDCBA9);
      send_beat(ACTION_CONVERT, 8'd4, 24'h000000);
      settle();

      // Zero masks: every channel adds nothing.
      load_masks(16'h0000, 16'h0000, 16'h0000);
      send_beat(ACTION_CONVERT, 8'd255, 24'h000000);
      send_beat(ACTION_CONVERT, 8'd1, 24'h000000);
      settle();

      // Full masks: runs longer than eight are clamped and the channels overlap.
      load_masks(16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_beat(ACTION_CONVERT, 8'd255, 24'h000000);
      send_beat(ACTION_CONVERT, 8'd128, 24'h000000);
      settle();

      // Overlapping upper bytes: the sum carries out of bit 15.
      load_masks(16'hFF00, 16'hFF00, 16'hFF00);
      send_beat(ACTION_CONVERT, 8'd255, 24'h000000);
      settle();

      // Split masks: only the first run of ones above the trailing zeros counts.
      load_masks(16'h0F0F, 16'hA0F0, 16'h8001);
      send_beat(ACTION_CONVERT, 8'd128, 24'h000000);
      send_beat(ACTION_CONVERT, 8'd255, 24'h000000);
      settle();

      // Random phases, each under its own mask layout.
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0: load_masks(RED_MASK_RESET, GREEN_MASK_RESET, BLUE_MASK_RESET);
            1: load_masks(16'h7C00, 16'h03E0, 16'h001F);
            2: load_masks(16'h001F, 16'h07E0, 16'hF800);
            3: load_masks(16'h0F00, 16'h00F0, 16'h000F);
            4: load_masks(16'($urandom), 16'($urandom), 16'($urandom));
            5: begin
               // Clean contiguous runs of random width and place, up to ten ones long.
               for (int lane = 0; lane < 3; lane++) begin
                  width = $urandom_range(1, 10);
                  pos   = $urandom_range(0, 16 - width);
                  lane_mask[lane] = 16'(((32'd1 << width) - 1) << pos);
               end
               load_masks(lane_mask[0], lane_mask[1], lane_mask[2]);
            end
            default: load_masks(16'h0000, 16'hFFFF, 16'($urandom));
         endcase
         repeat (PHASE_BEATS) random_beat();
         settle();
      end

      if (failures == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
